// ===== rtl/core/mdfs_pkg.sv =====
// Shared types and constants of the maze depth-first search core.
package mdfs_pkg;

    // Coordinate width inside the core: in-use bounds reach 15.
    localparam int CRD_W      = 4;
    localparam int MAX_IN_USE = 15;

    // Width of a coordinate on the ports and of each coordinate of a load address.
    localparam int PORT_CRD_W = 3;

    // Wall store: addressed by a 3-bit row and a 3-bit column.
    localparam int WALL_AW    = 2 * PORT_CRD_W;
    localparam int WALL_CELLS = 1 << WALL_AW;

    // Results per search at most.
    localparam int MAX_OUT = 64;

    // Default grid size.
    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;

    // Configuration data and index widths.
    localparam int CFG_DW = 4;
    localparam int CFG_IW = 2;

    // Request kinds on tuser.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Direction codes, tried in this order; DIR_DONE means all four were tried.
    localparam int DIR_W = 3;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        REG_ROWS_IN_USE = 2'd0,
        REG_COLS_IN_USE = 2'd1,
        REG_EXIT_ROW    = 2'd2,
        REG_EXIT_COL    = 2'd3
    } cfg_reg_t;

    // One stack frame: a cell and the next direction to try there.
    typedef struct packed {
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic [DIR_W-1:0] dir;
    } frame_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_LD,
        ST_EMIT_RD,
        ST_EMIT_TX,
        ST_FAIL
    } state_t;

endpackage

// ===== rtl/core/maze_dfs_path_finder_core.sv =====
// Maze depth-first search core: wall store, visited map, frame stack and result output.
// Load request: no result. Search request: a clearing pass over all VIS_CELLS visited-map
// entries (64 at 8 by 8), then per direction a probe only if outside the area or onto the
// exit, else a probe and a check (synchronous read, decision); a backtrack is a spent check, a pop and a load.
// Results: read, then sent once the output is free; next request once the last is loaded.
// Reset (aresetn low, sync): 8 rows, 8 cols, exit (7,7); walls read open via valid flags.
module maze_dfs_path_finder_core
    import mdfs_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [2:0] cell_row, [5:3] cell_col, [6] wall, [7] zero
    input  logic              s_tuser,   // [0] func
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [2:0] path_row, [5:3] path_col, [7:6] zero
    output logic              m_tuser,   // [0] found
    output logic              m_tlast,   // last result of a search
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    // The search can only ever walk the in-use area, which the 4-bit bounds cap at 15.
    localparam int VIS_ROWS  = (GRID_ROWS < MAX_IN_USE) ? GRID_ROWS : MAX_IN_USE;
    localparam int VIS_COLS  = (GRID_COLS < MAX_IN_USE) ? GRID_COLS : MAX_IN_USE;
    localparam int VIS_CELLS = VIS_ROWS * VIS_COLS;
    localparam int AW        = $clog2(VIS_CELLS);
    localparam int SPW       = $clog2(VIS_CELLS + 1);
    localparam int KW        = SPW + 1;

    localparam logic [CRD_W-1:0] VIS_ROWS_C = CRD_W'(VIS_ROWS);
    localparam logic [CRD_W-1:0] VIS_COLS_C = CRD_W'(VIS_COLS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DW-1:0]     rows_cfg_reg;
    logic [CFG_DW-1:0]     cols_cfg_reg;
    logic [PORT_CRD_W-1:0] exit_row_reg;
    logic [PORT_CRD_W-1:0] exit_col_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_DW'(8);
            cols_cfg_reg <= CFG_DW'(8);
            exit_row_reg <= PORT_CRD_W'(7);
            exit_col_reg <= PORT_CRD_W'(7);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_cfg_reg <= cfg_data;
                REG_COLS_IN_USE: cols_cfg_reg <= cfg_data;
                REG_EXIT_ROW:    exit_row_reg <= cfg_data[PORT_CRD_W-1:0];
                REG_EXIT_COL:    exit_col_reg <= cfg_data[PORT_CRD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [PORT_CRD_W-1:0] ld_row;
    logic [PORT_CRD_W-1:0] ld_col;
    logic                  ld_wall;
    logic                  req_take;
    logic                  load_take;
    logic                  search_take;

    assign ld_row      = s_tdata[2:0];
    assign ld_col      = s_tdata[5:3];
    assign ld_wall     = s_tdata[6];
    assign req_take    = s_tvalid && s_tready;
    assign load_take   = req_take && (s_tuser == FUNC_LOAD);
    assign search_take = req_take && (s_tuser == FUNC_SEARCH);

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CRD_W-1:0] cur_row_reg, cur_row_next;
    logic [CRD_W-1:0] cur_col_reg, cur_col_next;
    logic [DIR_W-1:0] dir_reg, dir_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [CRD_W-1:0] nb_row_reg, nb_row_next;
    logic [CRD_W-1:0] nb_col_reg, nb_col_next;
    logic [AW-1:0]    nb_idx_reg, nb_idx_next;
    logic [CRD_W-1:0] lim_rows_reg, lim_rows_next;
    logic [CRD_W-1:0] lim_cols_reg, lim_cols_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    total_reg, total_next;

    logic                  m_valid_reg, m_valid_next;
    logic [PORT_CRD_W-1:0] out_row_reg, out_row_next;
    logic [PORT_CRD_W-1:0] out_col_reg, out_col_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Wall store: one bit per cell plus a valid flag that reset clears,
    // so a cell never loaded reads open.
    // ------------------------------------------------------------------
    logic                     wall_mem [WALL_CELLS];
    logic [WALL_CELLS-1:0]    wall_ok_reg;
    logic [WALL_AW-1:0]       wall_waddr;
    logic [WALL_AW-1:0]       wall_raddr;
    logic                     wall_we;
    logic                     wall_rd_reg;
    logic                     wall_ok_rd_reg;
    logic                     in8_reg;

    assign wall_waddr = {ld_row, ld_col};
    assign wall_we    = load_take && (32'(ld_row) < GRID_ROWS) && (32'(ld_col) < GRID_COLS);

    always_ff @(posedge aclk) begin
        if (wall_we) begin
            wall_mem[wall_waddr] <= ld_wall;
        end
        wall_rd_reg <= wall_mem[wall_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_ok_reg <= '0;
        end else if (wall_we) begin
            wall_ok_reg[wall_waddr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Visited map: synchronous memory over the reachable area, wiped by a
    // pass over every entry at search start; the pass marks the start cell.
    // ------------------------------------------------------------------
    logic          vis_mem [VIS_CELLS];
    logic          vis_rd_reg;
    logic          visit_clear;
    logic          visit_set;
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic          vis_wdata;

    assign vis_we    = visit_clear || visit_set;
    assign vis_waddr = visit_clear ? k_reg[AW-1:0] : nb_idx_reg;
    assign vis_wdata = visit_clear ? (k_reg == '0) : 1'b1;

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Frame stack: synchronous memory, one write and one read port.
    // ------------------------------------------------------------------
    frame_t        stack_mem [VIS_CELLS];
    frame_t        stack_rd_reg;
    frame_t        stack_wdata;
    logic          stack_we;
    logic [AW-1:0] stack_raddr;
    logic [SPW-1:0] sp_dec;

    assign sp_dec      = sp_reg - SPW'(1);
    assign stack_wdata = '{row: cur_row_reg, col: cur_col_reg, dir: dir_reg + DIR_W'(1)};

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[sp_reg[AW-1:0]] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    // ------------------------------------------------------------------
    // Neighbor under test: position, exit hit, in-use bounds
    // ------------------------------------------------------------------
    logic [CRD_W-1:0] nb_row;
    logic [CRD_W-1:0] nb_col;
    logic             nb_exists;
    logic             exit_hit;
    logic             in_area;
    logic [AW-1:0]    nb_idx;
    logic             wall_hit;
    logic             blocked;
    logic             out_free;
    logic             emit_last;
    logic             emit_from_stack;
    logic             emit_cur;
    logic [KW-1:0]    path_total;

    always_comb begin
        nb_row    = cur_row_reg;
        nb_col    = cur_col_reg;
        nb_exists = 1'b1;
        case (dir_reg)
            DIR_EAST:  nb_col = cur_col_reg + CRD_W'(1);
            DIR_SOUTH: nb_row = cur_row_reg + CRD_W'(1);
            DIR_WEST: begin
                nb_col    = cur_col_reg - CRD_W'(1);
                nb_exists = (cur_col_reg != '0);
            end
            DIR_NORTH: begin
                nb_row    = cur_row_reg - CRD_W'(1);
                nb_exists = (cur_row_reg != '0);
            end
            default: nb_exists = 1'b0;
        endcase
    end

    // The exit is taken as soon as it is a neighbor, wall and bounds aside.
    assign exit_hit = nb_exists && (nb_row == {1'b0, exit_row_reg}) &&
                      (nb_col == {1'b0, exit_col_reg});
    assign in_area  = nb_exists && (nb_row < lim_rows_reg) && (nb_col < lim_cols_reg);
    assign nb_idx   = AW'(32'(nb_row) * VIS_COLS + 32'(nb_col));

    // Only the low 8 by 8 corner can hold loaded walls.
    assign wall_raddr = {nb_row[PORT_CRD_W-1:0], nb_col[PORT_CRD_W-1:0]};

    always_ff @(posedge aclk) begin
        wall_ok_rd_reg <= wall_ok_reg[wall_raddr];
        in8_reg        <= !nb_row[CRD_W-1] && !nb_col[CRD_W-1];
        vis_rd_reg     <= vis_mem[nb_idx];
    end

    assign wall_hit = wall_ok_rd_reg && wall_rd_reg && in8_reg;
    assign blocked  = wall_hit || vis_rd_reg;

    // Output register is free when empty or being drained this cycle.
    assign out_free        = !m_valid_reg || m_tready;
    assign emit_last       = (k_reg == total_reg - KW'(1));
    assign emit_from_stack = (k_reg < KW'(sp_reg));
    assign emit_cur        = (k_reg == KW'(sp_reg));

    // Path length: stack, then the cell the exit was seen from, then the exit; capped.
    always_comb begin
        path_total = KW'(sp_reg) + KW'(2);
        if (32'(path_total) > MAX_OUT) begin
            path_total = KW'(MAX_OUT);
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (search_take) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (k_reg == KW'(VIS_CELLS - 1)) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (dir_reg == DIR_DONE) begin
                    // all directions spent: backtrack, or give up on an empty stack
                    state_next = (sp_reg == '0) ? ST_FAIL : ST_POP_RD;
                end else if (exit_hit) begin
                    state_next = ST_EMIT_RD;
                end else if (in_area) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:   state_next = ST_PROBE;
            ST_POP_RD:  state_next = ST_POP_LD;
            ST_POP_LD:  state_next = ST_PROBE;
            ST_EMIT_RD: state_next = ST_EMIT_TX;
            ST_EMIT_TX: begin
                if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath controls and next values
    // ------------------------------------------------------------------
    always_comb begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        dir_next       = dir_reg;
        sp_next        = sp_reg;
        nb_row_next    = nb_row_reg;
        nb_col_next    = nb_col_reg;
        nb_idx_next    = nb_idx_reg;
        lim_rows_next  = lim_rows_reg;
        lim_cols_next  = lim_cols_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        visit_clear    = 1'b0;
        visit_set      = 1'b0;
        stack_we       = 1'b0;
        stack_raddr    = k_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (search_take) begin
                    // start from (0,0) with its frame already popped
                    cur_row_next  = '0;
                    cur_col_next  = '0;
                    dir_next      = DIR_EAST;
                    sp_next       = '0;
                    k_next        = '0;
                    // saturate the in-use bounds to 1..grid size, at most 15
                    lim_rows_next = (rows_cfg_reg == '0) ? CRD_W'(1) :
                                    (rows_cfg_reg > VIS_ROWS_C) ? VIS_ROWS_C : rows_cfg_reg;
                    lim_cols_next = (cols_cfg_reg == '0) ? CRD_W'(1) :
                                    (cols_cfg_reg > VIS_COLS_C) ? VIS_COLS_C : cols_cfg_reg;
                end
            end
            ST_CLEAR: begin
                // wipe one visited entry per cycle, advance the address
                visit_clear = 1'b1;
                k_next      = k_reg + KW'(1);
            end
            ST_PROBE: begin
                nb_row_next = nb_row;
                nb_col_next = nb_col;
                nb_idx_next = nb_idx;
                if (dir_reg != DIR_DONE) begin
                    if (exit_hit) begin
                        k_next     = '0;
                        total_next = path_total;
                    end else if (!in_area) begin
                        dir_next = dir_reg + DIR_W'(1);
                    end
                end
            end
            ST_CHECK: begin
                if (blocked) begin
                    dir_next = dir_reg + DIR_W'(1);
                end else begin
                    // descend: push the cell left behind with its next direction
                    stack_we     = 1'b1;
                    sp_next      = sp_reg + SPW'(1);
                    visit_set    = 1'b1;
                    cur_row_next = nb_row_reg;
                    cur_col_next = nb_col_reg;
                    dir_next     = DIR_EAST;
                end
            end
            ST_POP_RD: begin
                stack_raddr = sp_dec[AW-1:0];
                sp_next     = sp_dec;
            end
            ST_POP_LD: begin
                cur_row_next = stack_rd_reg.row;
                cur_col_next = stack_rd_reg.col;
                dir_next     = stack_rd_reg.dir;
            end
            ST_EMIT_RD: begin
                stack_raddr = k_reg[AW-1:0];
            end
            ST_EMIT_TX: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_found_next = 1'b1;
                    out_last_next  = emit_last;
                    if (emit_from_stack) begin
                        out_row_next = stack_rd_reg.row[PORT_CRD_W-1:0];
                        out_col_next = stack_rd_reg.col[PORT_CRD_W-1:0];
                    end else if (emit_cur) begin
                        out_row_next = cur_row_reg[PORT_CRD_W-1:0];
                        out_col_next = cur_col_reg[PORT_CRD_W-1:0];
                    end else begin
                        out_row_next = exit_row_reg;
                        out_col_next = exit_col_reg;
                    end
                    k_next = k_reg + KW'(1);
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_row_next   = '0;
                    out_col_next   = '0;
                    out_found_next = 1'b0;
                    out_last_next  = 1'b1;
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                    dir_next       = DIR_EAST;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            dir_reg     <= DIR_EAST;
            sp_reg      <= '0;
            k_reg       <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            dir_reg     <= dir_next;
            sp_reg      <= sp_next;
            k_reg       <= k_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        nb_row_reg    <= nb_row_next;
        nb_col_reg    <= nb_col_next;
        nb_idx_reg    <= nb_idx_next;
        lim_rows_reg  <= lim_rows_next;
        lim_cols_reg  <= lim_cols_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    // take requests only between searches
    assign s_tready = (state_reg == ST_IDLE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/maze_dfs_path_finder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the maze depth-first search core: loads, searches and settings.
module maze_dfs_path_finder_core_tb
    import mdfs_pkg::*;
();

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 280;

    typedef struct packed {
        logic [PORT_CRD_W-1:0] row;
        logic [PORT_CRD_W-1:0] col;
        logic                  found;
        logic                  last;
    } path_step_t;

    // Holds its own wall map and settings, solves each search and checks the path it emits.
    class maze_path_checker;
        bit                    blocked [WALL_CELLS];
        logic [CFG_DW-1:0]     rows_cfg;
        logic [CFG_DW-1:0]     cols_cfg;
        logic [PORT_CRD_W-1:0] exit_r;
        logic [PORT_CRD_W-1:0] exit_c;
        path_step_t            expected_steps [$];
        int                    failures;

        function new();
            rows_cfg = CFG_DW'(GRID_ROWS_DEF);
            cols_cfg = CFG_DW'(GRID_COLS_DEF);
            exit_r   = '1;
            exit_c   = '1;
            failures = 0;
            foreach (blocked[i]) blocked[i] = 1'b0;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_ROWS_IN_USE: rows_cfg = val;
                REG_COLS_IN_USE: cols_cfg = val;
                REG_EXIT_ROW:    exit_r   = val[PORT_CRD_W-1:0];
                REG_EXIT_COL:    exit_c   = val[PORT_CRD_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_step(int r, int c, bit f, bit l);
            path_step_t s;
            s.row   = r[PORT_CRD_W-1:0];
            s.col   = c[PORT_CRD_W-1:0];
            s.found = f;
            s.last  = l;
            expected_steps.push_back(s);
        endfunction

        function void take_request(logic func, logic [PORT_CRD_W-1:0] r,
                                   logic [PORT_CRD_W-1:0] c, logic w);
            if (func == FUNC_LOAD) begin
                blocked[{r, c}] = w;
            end else begin
                solve_maze();
            end
        endfunction

        // Walk east, south, west, north; the exit counts as soon as it is a neighbor.
        function void solve_maze();
            int               rows, cols, ex, ey, depth, row, col, nr, nc, total, k, n;
            logic [DIR_W-1:0] dir;
            int               fr [WALL_CELLS];
            int               fc [WALL_CELLS];
            logic [DIR_W-1:0] fd [WALL_CELLS];
            bit               seen [WALL_CELLS];
            bit               hit;
            rows = int'(rows_cfg);
            if (rows < 1) rows = 1;
            if (rows > GRID_ROWS_DEF) rows = GRID_ROWS_DEF;
            cols = int'(cols_cfg);
            if (cols < 1) cols = 1;
            if (cols > GRID_COLS_DEF) cols = GRID_COLS_DEF;
            ex = int'(exit_r);
            ey = int'(exit_c);
            foreach (seen[i]) seen[i] = 1'b0;
            seen[0] = 1'b1;
            fr[0] = 0;
            fc[0] = 0;
            fd[0] = DIR_EAST;
            depth = 1;
            hit   = 1'b0;
            row   = 0;
            col   = 0;
            dir   = DIR_EAST;
            while (!hit) begin
                if (depth == 0) begin
                    push_step(0, 0, 1'b0, 1'b1);
                    return;
                end
                depth--;
                row = fr[depth];
                col = fc[depth];
                dir = fd[depth];
                while (dir != DIR_DONE && !hit) begin
                    nr = row;
                    nc = col;
                    case (dir)
                        DIR_EAST:  nc = col + 1;
                        DIR_SOUTH: nr = row + 1;
                        DIR_WEST:  nc = col - 1;
                        default:   nr = row - 1;
                    endcase
                    if (nr == ex && nc == ey) begin
                        hit = 1'b1;
                    end else if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
                                 !blocked[nr * GRID_COLS_DEF + nc] &&
                                 !seen[nr * GRID_COLS_DEF + nc]) begin
                        seen[nr * GRID_COLS_DEF + nc] = 1'b1;
                        if (depth < WALL_CELLS) begin
                            fr[depth] = row;
                            fc[depth] = col;
                            fd[depth] = dir + 1'b1;
                            depth++;
                        end
                        row = nr;
                        col = nc;
                        dir = DIR_EAST;
                    end else begin
                        dir = dir + 1'b1;
                    end
                end
            end
            // Path is the stack from the start, then the cell left last, then the exit.
            total = (depth + 2 > MAX_OUT) ? MAX_OUT : depth + 2;
            k = 0;
            for (n = 0; n < depth && k < total; n++) begin
                push_step(fr[n], fc[n], 1'b1, k == total - 1);
                k++;
            end
            if (k < total) begin
                push_step(row, col, 1'b1, k == total - 1);
                k++;
            end
            if (k < total) push_step(ex, ey, 1'b1, 1'b1);
        endfunction

        function void check_step(path_step_t got);
            path_step_t want;
            if (expected_steps.size() == 0) begin
                $error("unexpected result: row %0d col %0d found %0b last %0b",
                       got.row, got.col, got.found, got.last);
                failures++;
                return;
            end
            want = expected_steps.pop_front();
            if (got.row !== want.row) begin
                $error("path_row: expected %0d, got %0d", want.row, got.row);
                failures++;
            end
            if (got.col !== want.col) begin
                $error("path_col: expected %0d, got %0d", want.col, got.col);
                failures++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, got.found);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tuser   = FUNC_LOAD;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_reg_t          cfg_index = REG_ROWS_IN_USE;
    logic [CFG_DW-1:0] cfg_data  = '0;

    maze_path_checker board = new();

    int idle_cycles = 0;
    int burst_left  = 0;
    int rx_cycle    = 0;
    int rx_stall    = 0;

    maze_dfs_path_finder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Observe every handshake; settings first, then requests, then results.
    always @(posedge aclk) begin : observe
        path_step_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                board.take_request(s_tuser, s_tdata[2:0], s_tdata[5:3], s_tdata[6]);
            end
            if (m_tvalid && m_tready) begin
                got.row   = m_tdata[2:0];
                got.col   = m_tdata[5:3];
                got.found = m_tuser;
                got.last  = m_tlast;
                board.check_step(got);
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sink: rotate through always ready, sparse stalls, long stalls and coin flips.
    always @(posedge aclk) begin
        case ((rx_cycle / 97) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, 12);
                end
            end
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
        rx_cycle++;
    end

    task automatic send_request(input logic func, input logic [2:0] r, input logic [2:0] c,
                                input logic w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w, c, r};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the request side until every expected result has left, then let the core settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [3:0] rows, input logic [3:0] cols,
                                  input logic [3:0] er, input logic [3:0] ec);
        write_reg(REG_ROWS_IN_USE, rows);
        write_reg(REG_COLS_IN_USE, cols);
        write_reg(REG_EXIT_ROW, er);
        write_reg(REG_EXIT_COL, ec);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small in-use bounds, sometimes zero or past the grid to hit saturation.
    function automatic logic [3:0] pick_bound();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    initial begin : stimulus
        int sent;
        int density;
        int phase_len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Open maze under reset settings, then a walled start that must be ignored.
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
        send_request(FUNC_LOAD, 3'd0, 3'd0, 1'b1);
        send_request(FUNC_SEARCH, 3'd5, 3'd2, 1'b0);
        // Box in the start: no path.
        send_request(FUNC_LOAD, 3'd0, 3'd1, 1'b1);
        send_request(FUNC_LOAD, 3'd1, 3'd0, 1'b1);
        send_request(FUNC_SEARCH, 3'd7, 3'd7, 1'b1);
        send_request(FUNC_LOAD, 3'd0, 3'd0, 1'b0);
        send_request(FUNC_LOAD, 3'd0, 3'd1, 1'b0);
        send_request(FUNC_LOAD, 3'd1, 3'd0, 1'b0);
        // A walled exit is still reached.
        send_request(FUNC_LOAD, 3'd7, 3'd7, 1'b1);
        send_request(FUNC_SEARCH, 3'd2, 3'd5, 1'b1);
        send_request(FUNC_LOAD, 3'd7, 3'd7, 1'b0);

        // Zero rows and oversized columns saturate; exit at the start cell.
        drain_results();
        write_settings(4'd0, 4'd15, 4'd0, 4'd0);
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
        // Full grid with the exit back at the start: longest path, cut at the result limit.
        drain_results();
        write_settings(4'd8, 4'd8, 4'd8, 4'd8);
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
        // Exit outside the in-use area but next to it.
        drain_results();
        write_settings(4'd3, 4'd3, 4'd3, 4'd2);
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
        // Exit out of reach of a small area.
        drain_results();
        write_settings(4'd2, 4'd2, 4'd7, 4'd7);
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);
        drain_results();
        write_settings(4'd15, 4'd15, 4'd7, 4'd7);
        send_request(FUNC_SEARCH, 3'd0, 3'd0, 1'b0);

        // Random phases: new settings, a run of wall loads at some density, searches between.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            write_settings(pick_bound(), pick_bound(), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)));
            density   = $urandom_range(0, 55);
            phase_len = $urandom_range(15, 45);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < 18)
                    send_request(FUNC_SEARCH, 3'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                else
                    send_request(FUNC_LOAD, 3'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)), $urandom_range(0, 99) < density);
                sent++;
            end
            send_request(FUNC_SEARCH, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
            sent++;
        end

        drain_results();
        if (board.failures == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/mdfs_pkg.sv
rtl/core/maze_dfs_path_finder_core.sv
tb/maze_dfs_path_finder_core_tb.sv
